/* hdl/pcbf_pkg.sv */
// ----------------------------------------------------------------------------
// pcbf_pkg
// Types and constants shared by the point color fusion unit.
// ----------------------------------------------------------------------------
package pcbf_pkg;

    localparam logic [1:0] STATUS_REJECT = 2'd0;
    localparam logic [1:0] STATUS_FIRST  = 2'd1;
    localparam logic [1:0] STATUS_FUSED  = 2'd2;

    localparam logic REG_GATE_RATIO    = 1'b0;
    localparam logic REG_PROCESS_NOISE = 1'b1;

    localparam logic [9:0]  GATE_RATIO_RESET    = 10'd307;
    localparam logic [15:0] PROCESS_NOISE_RESET = 16'd6554;

    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam logic [5:0] SQRT_LAST = 6'd15;

    typedef enum logic [3:0] {
        L_IDLE, L_GROW, L_SAT, L_SQ, L_PROD, L_NUM, L_DIVV, L_DIVM, L_SQRT, L_DONE
    } lane_state_t;

    typedef enum logic [2:0] {
        T_CLEAR, T_IDLE, T_READ, T_EVAL, T_FUSE, T_WRITE
    } top_state_t;

    typedef struct packed {
        logic [11:0] point_index;
        logic [15:0] obs_red;
        logic [15:0] obs_green;
        logic [15:0] obs_blue;
        logic [15:0] sigma_red;
        logic [15:0] sigma_green;
        logic [15:0] sigma_blue;
        logic [23:0] obs_distance;
        logic [31:0] obs_tick;
    } item_t;

    typedef struct packed {
        logic [2:0][15:0] mean;
        logic [2:0][15:0] spread;
        logic [23:0]      best_dist;
        logic [31:0]      seen;
        logic [15:0]      count;
    } entry_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [2:0][15:0] fused;
        logic [2:0][15:0] spread;
        logic [15:0]      seen_count;
    } result_t;

    typedef struct packed {
        logic [15:0] obs;
        logic [15:0] sigma;
        logic [15:0] mean;
        logic [15:0] spread;
        logic [31:0] dt;
        logic [15:0] noise;
    } lane_in_t;

    typedef struct packed {
        logic [15:0] mean;
        logic [15:0] spread;
    } lane_out_t;

endpackage

/* hdl/pcbf_if.sv */
// ----------------------------------------------------------------------------
// pcbf channel interfaces
// Valid/ready channels for observations and fusion results.
// ----------------------------------------------------------------------------
interface pcbf_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] point_index;
    logic [15:0] obs_red;
    logic [15:0] obs_green;
    logic [15:0] obs_blue;
    logic [15:0] sigma_red;
    logic [15:0] sigma_green;
    logic [15:0] sigma_blue;
    logic [23:0] obs_distance;
    logic [31:0] obs_tick;

    modport source (output valid, point_index, obs_red, obs_green, obs_blue,
                    sigma_red, sigma_green, sigma_blue, obs_distance, obs_tick,
                    input ready);
    modport sink   (input valid, point_index, obs_red, obs_green, obs_blue,
                    sigma_red, sigma_green, sigma_blue, obs_distance, obs_tick,
                    output ready);
endinterface

interface pcbf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] fused_red;
    logic [15:0] fused_green;
    logic [15:0] fused_blue;
    logic [15:0] spread_red;
    logic [15:0] spread_green;
    logic [15:0] spread_blue;
    logic [15:0] seen_count;

    modport source (output valid, status, fused_red, fused_green, fused_blue,
                    spread_red, spread_green, spread_blue, seen_count,
                    input ready);
    modport sink   (input valid, status, fused_red, fused_green, fused_blue,
                    spread_red, spread_green, spread_blue, seen_count,
                    output ready);
endinterface

/* hdl/pcbf_lane.sv */
// ----------------------------------------------------------------------------
// pcbf_lane
// One color channel: sigma growth, inverse-variance weights, bit-serial
// divisions for variance and mean, digit-serial square root.
// ----------------------------------------------------------------------------
module pcbf_lane
    import pcbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  lane_in_t  lane_in,
    output logic      done,
    output lane_out_t lane_out
);

    lane_state_t state_reg, state_next;

    logic [15:0] obs_reg, mean_reg, spread_reg, s_reg, noise_reg, c_reg;
    logic [31:0] dt_reg, cc_reg, ss_reg, var_reg, sq_reg;
    logic [47:0] gp_reg, ms_reg, rc_reg;
    logic [32:0] sum_reg, rem_reg;
    logic [63:0] prod_reg, num_reg;
    logic [49:0] mnum_reg;
    logic [5:0]  cnt_reg;
    logic [15:0] root_reg;
    logic [17:0] srem_reg;
    logic [15:0] mean_out_reg, spread_out_reg;

    // restoring divide step
    logic [33:0] dtrial;
    logic        qbit;
    logic [32:0] rem_step;
    logic [63:0] num_step;
    // square root step
    logic [19:0] strial_in;
    logic [17:0] strial;
    logic        sbit;
    logic [15:0] root_step;
    logic [17:0] srem_step;
    logic [16:0] root_rnd;
    logic [15:0] root_fin;
    // sigma growth
    logic [40:0] growth;
    logic [41:0] csum;
    logic [15:0] c_sat;

    always_comb
    begin
        dtrial   = {rem_reg, num_reg[63]};
        qbit     = dtrial >= {1'b0, sum_reg};
        rem_step = qbit ? 33'(dtrial - {1'b0, sum_reg}) : dtrial[32:0];
        num_step = {num_reg[62:0], qbit};

        strial_in = {srem_reg, sq_reg[31:30]};
        strial    = {root_reg, 2'b01};
        sbit      = strial_in >= {2'b00, strial};
        srem_step = sbit ? 18'(strial_in - {2'b00, strial}) : strial_in[17:0];
        root_step = {root_reg[14:0], sbit};
        root_rnd  = (srem_step > {2'b00, root_step}) ? 17'(root_step) + 17'd1
                                                     : {1'b0, root_step};
        if (root_rnd[16])
            root_fin = 16'hFFFF;
        else if (root_rnd[15:0] == 16'd0)
            root_fin = 16'd1;
        else
            root_fin = root_rnd[15:0];

        growth = 41'((49'(gp_reg) + 49'd128) >> 8);
        csum   = 42'(growth) + 42'(spread_reg);
        if (csum > 42'd65535)
            c_sat = 16'hFFFF;
        else if (csum == 42'd0)
            c_sat = 16'd1;
        else
            c_sat = csum[15:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE: if (start) state_next = L_GROW;
            L_GROW: state_next = L_SAT;
            L_SAT:  state_next = L_SQ;
            L_SQ:   state_next = L_PROD;
            L_PROD: state_next = L_NUM;
            L_NUM:  state_next = L_DIVV;
            L_DIVV: if (cnt_reg == DIV_LAST) state_next = L_DIVM;
            L_DIVM: if (cnt_reg == DIV_LAST) state_next = L_SQRT;
            L_SQRT: if (cnt_reg == SQRT_LAST) state_next = L_DONE;
            L_DONE: state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_comb
    begin
        done          = (state_reg == L_DONE);
        lane_out.mean   = mean_out_reg;
        lane_out.spread = spread_out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == L_NUM || state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                obs_reg    <= lane_in.obs;
                mean_reg   <= lane_in.mean;
                spread_reg <= lane_in.spread;
                s_reg      <= (lane_in.sigma == 16'd0) ? 16'd1 : lane_in.sigma;
                dt_reg     <= lane_in.dt;
                noise_reg  <= lane_in.noise;
            end
            L_GROW:
            begin
                gp_reg <= 48'(noise_reg) * 48'(dt_reg);
                ss_reg <= 32'(s_reg) * 32'(s_reg);
            end
            L_SAT: c_reg <= c_sat;
            L_SQ:  cc_reg <= 32'(c_reg) * 32'(c_reg);
            L_PROD:
            begin
                sum_reg  <= 33'(cc_reg) + 33'(ss_reg);
                prod_reg <= 64'(cc_reg) * 64'(ss_reg);
                ms_reg   <= 48'(mean_reg) * 48'(ss_reg);
                rc_reg   <= 48'(obs_reg) * 48'(cc_reg);
            end
            L_NUM:
            begin
                // half the divisor added first gives round half up
                num_reg  <= prod_reg + 64'(sum_reg >> 1);
                mnum_reg <= 50'(ms_reg) + 50'(rc_reg) + 50'(sum_reg >> 1);
                rem_reg  <= '0;
            end
            L_DIVV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    var_reg <= num_step[31:0];
                    num_reg <= 64'(mnum_reg);
                    rem_reg <= '0;
                end
                else
                begin
                    num_reg <= num_step;
                    rem_reg <= rem_step;
                end
            end
            L_DIVM:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    mean_out_reg <= num_step[15:0];
                    sq_reg       <= var_reg;
                    root_reg     <= '0;
                    srem_reg     <= '0;
                end
                else
                begin
                    num_reg <= num_step;
                    rem_reg <= rem_step;
                end
            end
            L_SQRT:
            begin
                sq_reg   <= {sq_reg[29:0], 2'b00};
                root_reg <= root_step;
                srem_reg <= srem_step;
                if (cnt_reg == SQRT_LAST)
                    spread_out_reg <= root_fin;
            end
            default: ;
        endcase
    end

endmodule

/* hdl/pcbf_merge.sv */
// ----------------------------------------------------------------------------
// pcbf_merge
// Combines the lane results with the stored entry into the write-back entry
// and the result item.
// ----------------------------------------------------------------------------
module pcbf_merge
    import pcbf_pkg::*;
(
    input  logic                 in_range,
    input  logic [1:0]           status,
    input  item_t                item,
    input  entry_t               stored,
    input  lane_out_t [2:0]      lanes,
    output logic                 wr_en,
    output entry_t               wr_entry,
    output result_t              result
);

    always_comb
    begin
        wr_entry = stored;
        case (status)
            STATUS_FIRST:
            begin
                wr_entry.mean[0]   = item.obs_red;
                wr_entry.mean[1]   = item.obs_green;
                wr_entry.mean[2]   = item.obs_blue;
                wr_entry.spread[0] = (item.sigma_red   == 16'd0) ? 16'd1 : item.sigma_red;
                wr_entry.spread[1] = (item.sigma_green == 16'd0) ? 16'd1 : item.sigma_green;
                wr_entry.spread[2] = (item.sigma_blue  == 16'd0) ? 16'd1 : item.sigma_blue;
                wr_entry.best_dist = item.obs_distance;
                wr_entry.seen      = item.obs_tick;
                wr_entry.count     = 16'd1;
            end
            STATUS_FUSED:
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    wr_entry.mean[ch]   = lanes[ch].mean;
                    wr_entry.spread[ch] = lanes[ch].spread;
                end
                if (item.obs_distance < stored.best_dist)
                    wr_entry.best_dist = item.obs_distance;
                wr_entry.seen  = item.obs_tick;
                wr_entry.count = (stored.count == 16'hFFFF) ? stored.count
                                                            : stored.count + 16'd1;
            end
            default: ;
        endcase

        wr_en = in_range && (status != STATUS_REJECT);

        if (in_range)
        begin
            result.status     = status;
            result.fused      = wr_entry.mean;
            result.spread     = wr_entry.spread;
            result.seen_count = wr_entry.count;
        end
        else
        begin
            result = '0;
        end
    end

endmodule

/* hdl/point_color_bayes_fusion_unit.sv */
// ----------------------------------------------------------------------------
// point_color_bayes_fusion_unit
// Per-point RGB fusion over a point table with a distance gate.
// ----------------------------------------------------------------------------
// Observations arrive on obs_in, one result per observation leaves on
// res_out, both valid/ready; a transfer happens when valid and ready are high.
// gate_ratio (addr 0) and process_noise (addr 4) sit on the APB port.
// One observation is in flight at a time. A rejected, first or out-of-table
// observation passes the table read, evaluation and write-back states before
// its result shows, and the next observation can transfer once the unit is
// back in idle. A fused one also waits in the fuse state for the per-channel
// lanes: five setup steps, two 64-step bit-serial divisions and a 16-step
// square root, run in three lanes side by side.
// After reset the count table is cleared one entry a cycle, all POINT_COUNT
// entries, with obs_in not ready; register writes are taken meanwhile.
// A result waits in the output register while the receiver stalls; the next
// observation is still accepted and worked on, and its write-back and result
// wait until the output register is free.
// ----------------------------------------------------------------------------
module point_color_bayes_fusion_unit
    import pcbf_pkg::*;
#(
    parameter int POINT_COUNT = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    pcbf_in_if.sink     obs_in,
    pcbf_out_if.source  res_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ADDR_W = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POINT_COUNT - 1);

    top_state_t state_reg, state_next;

    logic [9:0]  gate_reg;
    logic [15:0] noise_reg;

    item_t             item_reg;
    logic              in_range_reg;
    logic [ADDR_W-1:0] addr_reg, clr_reg;
    logic [1:0]        status_reg, status_eval;
    entry_t            rd_reg;

    logic [47:0] mean_mem   [POINT_COUNT];
    logic [47:0] spread_mem [POINT_COUNT];
    logic [23:0] dist_mem   [POINT_COUNT];
    logic [31:0] seen_mem   [POINT_COUNT];
    logic [15:0] count_mem  [POINT_COUNT];

    logic        out_valid_reg;
    result_t     out_reg;
    logic        out_free, mem_we, wr_en, lane_start;
    entry_t      wr_entry;
    result_t     result;
    logic [31:0] idx_ext, dt;
    logic [2:0]  lane_done;
    lane_in_t  [2:0] lane_in;
    lane_out_t [2:0] lane_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PROCESS_NOISE) ? 32'(noise_reg) : 32'(gate_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg  <= GATE_RATIO_RESET;
            noise_reg <= PROCESS_NOISE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_GATE_RATIO:    gate_reg  <= pwdata[9:0];
                REG_PROCESS_NOISE: noise_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign idx_ext  = 32'(obs_in.point_index);
    assign out_free = !out_valid_reg || res_out.ready;
    assign dt       = (item_reg.obs_tick >= rd_reg.seen) ? item_reg.obs_tick - rd_reg.seen
                                                         : 32'd0;

    always_comb
    begin
        if (!in_range_reg)
            status_eval = STATUS_REJECT;
        else if (rd_reg.count == 16'd0)
            status_eval = STATUS_FIRST;
        else if (rd_reg.best_dist != 24'd0 &&
                 {2'b00, item_reg.obs_distance, 8'd0} >
                 34'(rd_reg.best_dist) * 34'(gate_reg))
            status_eval = STATUS_REJECT;
        else
            status_eval = STATUS_FUSED;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_CLEAR: if (clr_reg == LAST_ADDR) state_next = T_IDLE;
            T_IDLE:  if (obs_in.valid) state_next = T_READ;
            T_READ:  state_next = T_EVAL;
            T_EVAL:  state_next = (status_eval == STATUS_FUSED) ? T_FUSE : T_WRITE;
            T_FUSE:  if (&lane_done) state_next = T_WRITE;
            T_WRITE: if (out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        obs_in.ready = (state_reg == T_IDLE);
        lane_start   = (state_reg == T_EVAL) && (status_eval == STATUS_FUSED);
        mem_we       = (state_reg == T_WRITE) && out_free && wr_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == T_CLEAR)
                clr_reg <= clr_reg + ADDR_W'(1);
            if (state_reg == T_WRITE && out_free)
                out_valid_reg <= 1'b1;
            else if (res_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (obs_in.valid && obs_in.ready)
        begin
            item_reg.point_index  <= obs_in.point_index;
            item_reg.obs_red      <= obs_in.obs_red;
            item_reg.obs_green    <= obs_in.obs_green;
            item_reg.obs_blue     <= obs_in.obs_blue;
            item_reg.sigma_red    <= obs_in.sigma_red;
            item_reg.sigma_green  <= obs_in.sigma_green;
            item_reg.sigma_blue   <= obs_in.sigma_blue;
            item_reg.obs_distance <= obs_in.obs_distance;
            item_reg.obs_tick     <= obs_in.obs_tick;
            in_range_reg          <= idx_ext < 32'(POINT_COUNT);
            addr_reg              <= idx_ext[ADDR_W-1:0];
        end
        if (state_reg == T_EVAL)
            status_reg <= status_eval;
        if (state_reg == T_WRITE && out_free)
            out_reg <= result;
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if (state_reg == T_READ)
        begin
            rd_reg.mean      <= mean_mem[addr_reg];
            rd_reg.spread    <= spread_mem[addr_reg];
            rd_reg.best_dist <= dist_mem[addr_reg];
            rd_reg.seen      <= seen_mem[addr_reg];
            rd_reg.count     <= count_mem[addr_reg];
        end
        if (state_reg == T_CLEAR)
            count_mem[clr_reg] <= 16'd0;
        else if (mem_we)
            count_mem[addr_reg] <= wr_entry.count;
        if (mem_we)
        begin
            mean_mem[addr_reg]   <= wr_entry.mean;
            spread_mem[addr_reg] <= wr_entry.spread;
            dist_mem[addr_reg]   <= wr_entry.best_dist;
            seen_mem[addr_reg]   <= wr_entry.seen;
        end
    end

    always_comb
    begin
        lane_in[0].obs   = item_reg.obs_red;
        lane_in[1].obs   = item_reg.obs_green;
        lane_in[2].obs   = item_reg.obs_blue;
        lane_in[0].sigma = item_reg.sigma_red;
        lane_in[1].sigma = item_reg.sigma_green;
        lane_in[2].sigma = item_reg.sigma_blue;
        for (int ch = 0; ch < 3; ch++)
        begin
            lane_in[ch].mean   = rd_reg.mean[ch];
            lane_in[ch].spread = rd_reg.spread[ch];
            lane_in[ch].dt     = dt;
            lane_in[ch].noise  = noise_reg;
        end
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        pcbf_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (lane_start),
            .lane_in  (lane_in[ch]),
            .done     (lane_done[ch]),
            .lane_out (lane_out[ch])
        );
    end

    pcbf_merge u_merge (
        .in_range (in_range_reg),
        .status   (status_reg),
        .item     (item_reg),
        .stored   (rd_reg),
        .lanes    (lane_out),
        .wr_en    (wr_en),
        .wr_entry (wr_entry),
        .result   (result)
    );

    assign res_out.valid        = out_valid_reg;
    assign res_out.status       = out_reg.status;
    assign res_out.fused_red    = out_reg.fused[0];
    assign res_out.fused_green  = out_reg.fused[1];
    assign res_out.fused_blue   = out_reg.fused[2];
    assign res_out.spread_red   = out_reg.spread[0];
    assign res_out.spread_green = out_reg.spread[1];
    assign res_out.spread_blue  = out_reg.spread[2];
    assign res_out.seen_count   = out_reg.seen_count;

    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == T_WRITE)
        else $error("result raised outside write-back");

    a_lane_start_fuse: assert property (@(posedge clk) disable iff (!rst_n)
        lane_start |=> state_reg == T_FUSE)
        else $error("lanes started without entering fuse wait");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        obs_in.valid && obs_in.ready |=> state_reg == T_READ)
        else $error("accepted observation not followed by table read");

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == T_FUSE |-> (&lane_done) || !(|lane_done))
        else $error("lanes out of step");

endmodule
